### src/sdru_pkg.sv
// shared types and constants for the signed divide/remainder unit
`default_nettype none
package sdru_pkg;
	localparam int unsigned XLEN = 64;
	localparam int unsigned BITS_PER_STAGE = 4;
	localparam int unsigned NUM_STAGES = XLEN / BITS_PER_STAGE;

	// per-item control that travels down the pipe
	typedef struct packed {
		logic kind;
		logic wide;
		logic num_neg;
		logic den_neg;
		logic dbz;
	} ctl_t;
endpackage
`default_nettype wire

### src/sdru_stage.sv
// one restoring-division stage: retires BITS_PER_STAGE quotient bits per cycle
`default_nettype none
module sdru_stage import sdru_pkg::*; (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              in_valid,
	input  wire ctl_t        in_ctl,
	input  wire [XLEN-1:0]   in_rem,
	input  wire [XLEN-1:0]   in_quo,
	input  wire [XLEN-1:0]   in_den,
	output logic             out_valid_s1,
	output ctl_t             out_ctl_s1,
	output logic [XLEN-1:0]  out_rem_s1,
	output logic [XLEN-1:0]  out_quo_s1,
	output logic [XLEN-1:0]  out_den_s1
);
	logic [XLEN-1:0] rem_n, quo_n;
	logic [XLEN:0]   trial;

	// quo shifts out dividend bits from the top while quotient bits enter the bottom
	always_comb begin
		rem_n = in_rem;
		quo_n = in_quo;
		trial = '0;
		for (int i = 0; i < BITS_PER_STAGE; i++) begin
			trial = {rem_n, quo_n[XLEN-1]} - {1'b0, in_den};
			if (!trial[XLEN]) begin
				rem_n = trial[XLEN-1:0];
				quo_n = {quo_n[XLEN-2:0], 1'b1};
			end else begin
				rem_n = {rem_n[XLEN-2:0], quo_n[XLEN-1]};
				quo_n = {quo_n[XLEN-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s1 <= 1'b0;
		end else begin
			out_valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		out_ctl_s1 <= in_ctl;
		out_rem_s1 <= rem_n;
		out_quo_s1 <= quo_n;
		out_den_s1 <= in_den;
	end
endmodule
`default_nettype wire

### src/signed_divide_remainder_unit.sv
// top level of the pipelined signed divide/remainder unit
// usage:
//  - drive kind, wide, dividend, divisor and pulse start; busy is always low, so
//    a transfer happens at every edge with start high, one item per cycle
//  - kind 0 returns the truncated quotient, kind 1 the remainder (sign of dividend)
//  - wide 0 uses the low 32 bits and sign-extends the 32-bit result
//  - a zero divisor gives value 0 with div_by_zero set
//  - pipeline from start to done: one operand stage, 16 divide stages (NUM_STAGES at
//    64 bits and 4 bits per stage) and one sign-fixup stage
//  - throughput is one item per cycle, set by the fully pipelined divide stages
//  - done marks value/div_by_zero for exactly one cycle; results cannot be held off
//  - reset clears all valid bits, so no stale done follows reset
`default_nettype none
module signed_divide_remainder_unit import sdru_pkg::*; (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                start,
	output logic               busy,
	input  wire                kind,
	input  wire                wide,
	input  wire  signed [63:0] dividend,
	input  wire  signed [63:0] divisor,
	output logic               done,
	output logic signed [63:0] value,
	output logic               div_by_zero
);
	logic [XLEN-1:0] num_x, den_x, num_mag, den_mag;
	logic            v_s1;
	ctl_t            c_s1;
	logic [XLEN-1:0] n_s1, d_s1;

	logic            v [NUM_STAGES+1];
	ctl_t            c [NUM_STAGES+1];
	logic [XLEN-1:0] r [NUM_STAGES+1];
	logic [XLEN-1:0] q [NUM_STAGES+1];
	logic [XLEN-1:0] d [NUM_STAGES+1];

	logic [XLEN-1:0] mag, res;
	logic            neg;

	assign busy = 1'b0;

	always_comb begin
		num_x = wide ? dividend : {{32{dividend[31]}}, dividend[31:0]};
		den_x = wide ? divisor  : {{32{divisor[31]}},  divisor[31:0]};
		num_mag = num_x[XLEN-1] ? -num_x : num_x;
		den_mag = den_x[XLEN-1] ? -den_x : den_x;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		c_s1 <= '{kind: kind, wide: wide, num_neg: num_x[XLEN-1],
			den_neg: den_x[XLEN-1], dbz: (den_x == '0)};
		n_s1 <= num_mag;
		d_s1 <= den_mag;
	end

	assign v[0] = v_s1;
	assign c[0] = c_s1;
	assign r[0] = '0;
	assign q[0] = n_s1;
	assign d[0] = d_s1;

	for (genvar g = 0; g < NUM_STAGES; g++) begin : g_stage
		sdru_stage u_stage (
			.clk(clk), .arst_n(arst_n),
			.in_valid(v[g]), .in_ctl(c[g]), .in_rem(r[g]), .in_quo(q[g]), .in_den(d[g]),
			.out_valid_s1(v[g+1]), .out_ctl_s1(c[g+1]), .out_rem_s1(r[g+1]),
			.out_quo_s1(q[g+1]), .out_den_s1(d[g+1])
		);
	end

	always_comb begin
		mag = c[NUM_STAGES].kind ? r[NUM_STAGES] : q[NUM_STAGES];
		neg = c[NUM_STAGES].kind ? c[NUM_STAGES].num_neg
			: (c[NUM_STAGES].num_neg ^ c[NUM_STAGES].den_neg);
		res = neg ? -mag : mag;
		if (!c[NUM_STAGES].wide) begin
			res = {{32{res[31]}}, res[31:0]};
		end
		if (c[NUM_STAGES].dbz) begin
			res = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= v[NUM_STAGES];
		end
	end

	always_ff @(posedge clk) begin
		value       <= res;
		div_by_zero <= c[NUM_STAGES].dbz;
	end
endmodule
`default_nettype wire

### src/sdru_checker.sv
// port-level checks for the signed divide/remainder unit, bound to the top level
`default_nettype none
module sdru_checker import sdru_pkg::*; (
	input wire               clk,
	input wire               arst_n,
	input wire               start,
	input wire               busy,
	input wire               done,
	input wire signed [63:0] value,
	input wire               div_by_zero
);
	localparam int unsigned LAT = NUM_STAGES + 2;

	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##LAT done) else $error("result missing");
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, LAT)) else $error("result without start");
	a_dbz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && div_by_zero) |-> (value == 64'sd0)) else $error("nonzero on dbz");
endmodule

bind signed_divide_remainder_unit sdru_checker u_sdru_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
	.value(value), .div_by_zero(div_by_zero)
);
`default_nettype wire

### tb/tb.sv
// testbench for the pipelined signed divide/remainder unit
`timescale 1ns / 100ps
`default_nettype none
module tb;
	import sdru_pkg::*;

	localparam int LATENCY = NUM_STAGES + 2;
	localparam int CYCLE_LIMIT = 200000;
	localparam logic KIND_REM = 1'b1;
	localparam logic MODE_32 = 1'b0;
	localparam logic MODE_64 = 1'b1;
	localparam logic [63:0] MIN64 = 64'h8000_0000_0000_0000;
	localparam logic [63:0] MAX64 = 64'h7fff_ffff_ffff_ffff;
	localparam logic [63:0] MINUS_ONE = 64'hffff_ffff_ffff_ffff;

	typedef struct packed {
		logic kind;
		logic wide;
		logic [63:0] dividend;
		logic [63:0] divisor;
	} div_op_t;

	typedef struct packed {
		logic [63:0] value;
		logic dbz;
	} div_res_t;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic kind;
	logic wide;
	logic signed [63:0] dividend;
	logic signed [63:0] divisor;
	logic done;
	logic signed [63:0] value;
	logic div_by_zero;

	div_op_t pending_ops[$];
	div_res_t expected_results[$];
	int errors;
	int cycles;
	bit hold_sender;
	bit no_gaps;
	int gap_left;

	signed_divide_remainder_unit DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.kind(kind), .wide(wide), .dividend(dividend), .divisor(divisor),
		.done(done), .value(value), .div_by_zero(div_by_zero)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	function automatic logic [63:0] sext32(logic [63:0] v);
		return {{32{v[31]}}, v[31:0]};
	endfunction

	function automatic div_res_t divide_truncating(div_op_t op);
		div_res_t r;
		logic [63:0] num, den, num_mag, den_mag, mag;
		logic neg;
		num = op.wide ? op.dividend : sext32(op.dividend);
		den = op.wide ? op.divisor : sext32(op.divisor);
		if (den == 64'd0) begin
			r.value = 64'd0;
			r.dbz = 1'b1;
			return r;
		end
		num_mag = num[63] ? -num : num;
		den_mag = den[63] ? -den : den;
		if (op.kind == KIND_REM) begin
			mag = num_mag % den_mag;
			neg = num[63];
		end else begin
			mag = num_mag / den_mag;
			neg = num[63] ^ den[63];
		end
		r.value = neg ? -mag : mag;
		if (!op.wide)
			r.value = sext32(r.value);
		r.dbz = 1'b0;
		return r;
	endfunction

	function automatic logic [63:0] rand64();
		logic [63:0] v;
		v = {$urandom, $urandom};
		case ($urandom_range(0, 5))
			0: v = v >> $urandom_range(0, 63);
			1: v = -(v >> $urandom_range(0, 63));
			2: v = {$urandom, 32'd0} | 64'($urandom_range(0, 3));
			default: ;
		endcase
		return v;
	endfunction

	task automatic push_op(logic k, logic w, logic [63:0] a, logic [63:0] b);
		div_op_t op;
		op.kind = k;
		op.wide = w;
		op.dividend = a;
		op.divisor = b;
		pending_ops.push_back(op);
	endtask

	// driver: transfer on rising edge with start high and busy low
	always @(negedge clk) begin
		if (arst_n) begin
			if (start && !busy && pending_ops.size() > 0)
				void'(pending_ops.pop_front());
			if (hold_sender || pending_ops.size() == 0) begin
				start <= 1'b0;
			end else if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				start <= 1'b0;
			end else if (!no_gaps && $urandom_range(0, 9) == 0) begin
				gap_left <= int'($urandom_range(0, 8));
				start <= 1'b0;
			end else begin
				start <= 1'b1;
				kind <= pending_ops[0].kind;
				wide <= pending_ops[0].wide;
				dividend <= pending_ops[0].dividend;
				divisor <= pending_ops[0].divisor;
			end
		end
	end

	// predictor on transfer, checker on done
	always @(posedge clk) begin
		div_op_t op;
		div_res_t exp_r;
		cycles <= cycles + 1;
		if (arst_n && start && !busy) begin
			op.kind = kind;
			op.wide = wide;
			op.dividend = dividend;
			op.divisor = divisor;
			expected_results.push_back(divide_truncating(op));
		end
		if (arst_n && done) begin
			if (expected_results.size() == 0) begin
				$error("unexpected result value=%h div_by_zero=%b", value, div_by_zero);
				errors++;
			end else begin
				exp_r = expected_results.pop_front();
				if (value !== exp_r.value) begin
					$error("value: expected %h actual %h", exp_r.value, value);
					errors++;
				end
				if (div_by_zero !== exp_r.dbz) begin
					$error("div_by_zero: expected %b actual %b", exp_r.dbz, div_by_zero);
					errors++;
				end
			end
		end
	end

	initial begin
		errors = 0;
		cycles = 0;
		hold_sender = 1'b0;
		no_gaps = 1'b0;
		gap_left = 0;
		start = 1'b0;
		kind = 1'b0;
		wide = 1'b0;
		dividend = '0;
		divisor = '0;
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed corners
		for (int k = 0; k < 2; k++) begin
			push_op(k[0], MODE_64, MIN64, MINUS_ONE);
			push_op(k[0], MODE_32, 64'h0000_0000_8000_0000, MINUS_ONE);
			push_op(k[0], MODE_64, 64'd7, 64'd0);
			push_op(k[0], MODE_32, 64'd7, 64'hffff_ffff_0000_0000);
			push_op(k[0], MODE_64, MAX64, 64'd1);
			push_op(k[0], MODE_64, -64'sd7, 64'sd2);
			push_op(k[0], MODE_64, 64'sd7, -64'sd2);
			push_op(k[0], MODE_32, 64'h1234_5678_ffff_fff9, 64'hdead_beef_0000_0002);
			push_op(k[0], MODE_64, MIN64, MAX64);
			push_op(k[0], MODE_32, MINUS_ONE, 64'h0000_0000_7fff_ffff);
		end
		wait (pending_ops.size() == 0);
		// sender pause until the pipe drains
		hold_sender = 1'b1;
		wait (expected_results.size() == 0);
		@(negedge clk);
		hold_sender = 1'b0;

		for (int i = 0; i < 850; i++) begin
			logic [63:0] b;
			b = rand64();
			if ($urandom_range(0, 30) == 0)
				b = $urandom_range(0, 1) ? MINUS_ONE : 64'd0;
			push_op(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
				($urandom_range(0, 30) == 0) ? MIN64 : rand64(), b);
			if (i == 700) begin
				wait (pending_ops.size() == 0);
				no_gaps = 1'b1;
			end
		end
		wait (pending_ops.size() == 0 && !start);
		wait (expected_results.size() == 0);
		repeat (LATENCY + 4) @(posedge clk);
		if (errors == 0)
			$display("** signed_divide_remainder_unit: PASSED **");
		else
			$display("** signed_divide_remainder_unit: FAILED **");
		$finish;
	end

	initial begin
		wait (cycles >= CYCLE_LIMIT);
		$display("timeout after %0d cycles", cycles);
		$display("** signed_divide_remainder_unit: FAILED **");
		$finish;
	end
endmodule
`default_nettype wire
